// ----- hw/rtl/pip_pkg.sv -----
// Shared constants and codes for the point-in-polygon test block.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MIN_VERTICES = 3;
    localparam int COORD_BITS   = 16;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

endpackage

// ----- hw/rtl/pip_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/point_in_polygon_test.sv -----
// Point-in-polygon test (even-odd crossing rule) over a stored vertex table.
//
// Clear, append and unused codes are taken in the cycle start is seen with busy
// low and answer on the next cycle with o_strobe high; busy stays low, so such
// items may follow back to back. A test of a polygon with N >= 3 vertices holds
// busy until it answers and answers in the cycle busy falls: the vertex memory has
// one read port, so the walk reads the closing vertex and then every vertex in
// order, one per cycle, followed by a three-stage edge pipeline (order and
// subtract, multiply, compare and toggle). A test of fewer than three vertices
// answers on the next cycle with status invalid. Results cannot be held off.
// The vertex memory needs no clearing after reset; only entries below the
// vertex count are ever read.
module point_in_polygon_test (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [pip_pkg::FUNC_W-1:0]             i_func,
    input  logic signed [pip_pkg::COORD_BITS-1:0]  i_coord_x,
    input  logic signed [pip_pkg::COORD_BITS-1:0]  i_coord_y,
    output logic                                   o_strobe,
    output logic                                   o_inside_res,
    output logic [pip_pkg::CNT_W-1:0]              o_vertex_count,
    output logic [pip_pkg::STAT_W-1:0]             o_status
);
    import pip_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    t_state r_state;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_step;
    logic              r_strobe;
    logic              r_inside_res;
    logic [STAT_W-1:0] r_status;
    logic [CNT_W-1:0]  r_vcount_out;
    logic              r_inside;
    logic              r_rd_vld;
    logic              r_rd_first;
    logic              r_s1_vld;
    logic              r_s2_vld;

    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic signed [COORD_BITS-1:0] r_ox;
    logic signed [COORD_BITS-1:0] r_oy;

    logic signed [DIFF_W-1:0] r_d1;
    logic signed [DIFF_W-1:0] r_d2;
    logic signed [DIFF_W-1:0] r_d3;
    logic signed [DIFF_W-1:0] r_d4;
    logic                     r_s1_span;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic                     r_s2_span;

    logic                         accept;
    logic                         wr_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [CNT_W-1:0]             last_idx;
    logic [CNT_W-1:0]             step_m1;
    logic [2*COORD_BITS-1:0]      rd_data;
    logic signed [COORD_BITS-1:0] nx;
    logic signed [COORD_BITS-1:0] ny;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic                         swap;
    logic                         span;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (i_func == FUNC_APPEND) && (r_count < CNT_W'(MAX_VERTICES));

    // First read fetches the closing vertex, then vertices 0..N-1
    assign last_idx = r_count - 1'b1;
    assign step_m1  = r_step - 1'b1;
    assign rd_addr  = (r_step == '0) ? last_idx[ADDR_W-1:0] : step_m1[ADDR_W-1:0];

    pip_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign nx = $signed(rd_data[2*COORD_BITS-1:COORD_BITS]);
    assign ny = $signed(rd_data[COORD_BITS-1:0]);

    // Order edge endpoints by x, and test whether the edge straddles the point's x
    always_comb begin
        swap = (nx > r_ox);
        ax   = swap ? r_ox : nx;
        ay   = swap ? r_oy : ny;
        bx   = swap ? nx   : r_ox;
        by   = swap ? ny   : r_oy;
        span = ((nx < r_px) == (r_px <= r_ox));
    end

    // Edge datapath: subtract, then multiply
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_rd_vld) begin
            r_ox <= nx;
            r_oy <= ny;
        end
        r_d1      <= DIFF_W'(r_py) - DIFF_W'(ay);
        r_d2      <= DIFF_W'(bx) - DIFF_W'(ax);
        r_d3      <= DIFF_W'(by) - DIFF_W'(ay);
        r_d4      <= DIFF_W'(r_px) - DIFF_W'(ax);
        r_s1_span <= span;
        r_p1      <= r_d1 * r_d2;
        r_p2      <= r_d3 * r_d4;
        r_s2_span <= r_s1_span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_step       <= '0;
            r_strobe     <= 1'b0;
            r_inside_res <= 1'b0;
            r_status     <= STAT_OK;
            r_vcount_out <= '0;
            r_inside     <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_first   <= 1'b0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
        end else begin
            r_strobe   <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_s1_vld   <= r_rd_vld && !r_rd_first;
            r_s2_vld   <= r_s1_vld;
            if (r_s2_vld && r_s2_span && (r_p1 < r_p2)) begin
                r_inside <= !r_inside;
            end
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_inside_res <= 1'b0;
                        r_status     <= STAT_OK;
                        r_vcount_out <= r_count;
                        r_strobe     <= 1'b1;
                        case (i_func)
                            FUNC_CLEAR: begin
                                r_count      <= '0;
                                r_vcount_out <= '0;
                            end
                            FUNC_APPEND: begin
                                if (r_count < CNT_W'(MAX_VERTICES)) begin
                                    r_count      <= r_count + 1'b1;
                                    r_vcount_out <= r_count + 1'b1;
                                end else begin
                                    r_status <= STAT_FULL;
                                end
                            end
                            FUNC_TEST: begin
                                if (r_count < CNT_W'(MIN_VERTICES)) begin
                                    r_status <= STAT_INVALID;
                                end else begin
                                    // hold the result until the walk finishes
                                    r_strobe <= 1'b0;
                                    r_inside <= 1'b0;
                                    r_step   <= '0;
                                    r_state  <= ST_WALK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    r_rd_vld   <= 1'b1;
                    r_rd_first <= (r_step == '0);
                    r_step     <= r_step + 1'b1;
                    if (r_step == r_count) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_rd_vld && !r_s1_vld && !r_s2_vld) begin
                        r_strobe     <= 1'b1;
                        r_inside_res <= r_inside;
                        r_status     <= STAT_OK;
                        r_vcount_out <= r_count;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_inside_res   = r_inside_res;
    assign o_vertex_count = r_vcount_out;
    assign o_status       = r_status;

`ifndef NO_ASSERTIONS
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("test finished without a result strobe");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond table depth");

    a_invalid_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STAT_INVALID)) |-> !o_inside_res)
        else $error("invalid polygon reported inside");

    a_read_in_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state != ST_IDLE))
        else $error("vertex read outside a test walk");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_count))
        else $error("vertex count changed during a test");
`endif

endmodule

// ----- tb/sv/point_in_polygon_test_tb.sv -----
// Testbench for the point-in-polygon block: directed table, random polygons, scoreboard.
module point_in_polygon_test_tb;
    import pip_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic              in_poly;
        logic [CNT_W-1:0]  count;
        logic [STAT_W-1:0] status;
    } t_poly_answer;

    typedef struct {
        logic [FUNC_W-1:0] func;
        int                x;
        int                y;
        bit                typed;
        t_poly_answer      answer;
    } t_stim_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [FUNC_W-1:0]            i_func;
    logic signed [COORD_BITS-1:0] i_coord_x;
    logic signed [COORD_BITS-1:0] i_coord_y;
    logic                         o_strobe;
    logic                         o_inside_res;
    logic [CNT_W-1:0]             o_vertex_count;
    logic [STAT_W-1:0]            o_status;

    point_in_polygon_test DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_strobe       (o_strobe),
        .o_inside_res   (o_inside_res),
        .o_vertex_count (o_vertex_count),
        .o_status       (o_status)
    );

    // Predicted polygon table and the answers still owed by the block
    logic signed [COORD_BITS-1:0] poly_x [0:MAX_VERTICES-1];
    logic signed [COORD_BITS-1:0] poly_y [0:MAX_VERTICES-1];
    int                           poly_len;
    t_poly_answer                 pending_answers [$];
    int                           mismatch_count;
    int                           items_sent;
    int                           burst_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        end
    endtask

    // Even-odd crossing walk, closing edge first; products are exact in 64 bits
    function automatic bit crossing_parity(input logic signed [COORD_BITS-1:0] qx,
                                           input logic signed [COORD_BITS-1:0] qy);
        longint px, py, ox, oy, nx, ny, ax, ay, bx, by;
        bit     flag;
        px   = qx;
        py   = qy;
        ox   = poly_x[poly_len-1];
        oy   = poly_y[poly_len-1];
        flag = 1'b0;
        for (int i = 0; i < poly_len; i++) begin
            nx = poly_x[i];
            ny = poly_y[i];
            if (nx > ox) begin
                ax = ox; ay = oy; bx = nx; by = ny;
            end else begin
                ax = nx; ay = ny; bx = ox; by = oy;
            end
            if (((nx < px) == (px <= ox)) &&
                ((py - ay) * (bx - ax) < (by - ay) * (px - ax)))
                flag = !flag;
            ox = nx;
            oy = ny;
        end
        return flag;
    endfunction

    function automatic t_poly_answer apply_polygon_op(input logic [FUNC_W-1:0] f,
                                                      input logic signed [COORD_BITS-1:0] x,
                                                      input logic signed [COORD_BITS-1:0] y);
        t_poly_answer ans;
        ans.in_poly = 1'b0;
        ans.status  = STAT_OK;
        case (f)
            FUNC_CLEAR: poly_len = 0;
            FUNC_APPEND: begin
                if (poly_len >= MAX_VERTICES) begin
                    ans.status = STAT_FULL;
                end else begin
                    poly_x[poly_len] = x;
                    poly_y[poly_len] = y;
                    poly_len++;
                end
            end
            FUNC_TEST: begin
                if (poly_len < MIN_VERTICES)
                    ans.status = STAT_INVALID;
                else
                    ans.in_poly = crossing_parity(x, y);
            end
            default: ;
        endcase
        ans.count = CNT_W'(poly_len);
        return ans;
    endfunction

    // Present one item at the falling edge, hold it until taken, then log its answer
    task automatic issue_item(input logic [FUNC_W-1:0] f,
                              input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input bit typed, input t_poly_answer typed_ans);
        int           gap;
        t_poly_answer ans;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                start     <= 1'b0;
                i_func    <= FUNC_W'($urandom());
                i_coord_x <= COORD_BITS'($urandom());
                i_coord_y <= COORD_BITS'($urandom());
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start     <= 1'b1;
        i_func    <= f;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(posedge i_clk); while (busy);
        ans = apply_polygon_op(f, x, y);
        pending_answers.push_back(typed ? typed_ans : ans);
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        t_poly_answer want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                want = pending_answers.pop_front();
                if (o_inside_res !== want.in_poly)
                    report_mismatch("inside_res", o_inside_res, want.in_poly);
                if (o_vertex_count !== want.count)
                    report_mismatch("vertex_count", o_vertex_count, want.count);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int lim);
        if (lim >= 32768)
            return COORD_BITS'($urandom());
        return COORD_BITS'(int'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    initial begin
        t_stim_row    directed_rows [0:22];
        t_poly_answer no_answer;
        int           n_vert, n_tests, lim, pick, min_x, max_x, min_y, max_y, vi;
        logic signed [COORD_BITS-1:0] vx, vy, qx, qy;

        start          = 1'b0;
        i_func         = FUNC_CLEAR;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_rst_n        = 1'b0;
        poly_len       = 0;
        mismatch_count = 0;
        items_sent     = 0;
        burst_left     = 0;
        no_answer      = '0;

        directed_rows = '{
            '{FUNC_TEST,        0,      0, 1, '{1'b0, 7'd0, STAT_INVALID}},
            '{FUNC_UNUSED,      5,      5, 1, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_APPEND, -32768, -32768, 1, '{1'b0, 7'd1, STAT_OK}},
            '{FUNC_TEST,        0,      0, 1, '{1'b0, 7'd1, STAT_INVALID}},
            '{FUNC_APPEND,  32767, -32768, 1, '{1'b0, 7'd2, STAT_OK}},
            '{FUNC_TEST,        0,      0, 1, '{1'b0, 7'd2, STAT_INVALID}},
            '{FUNC_APPEND,  32767,  32767, 1, '{1'b0, 7'd3, STAT_OK}},
            '{FUNC_APPEND, -32768,  32767, 1, '{1'b0, 7'd4, STAT_OK}},
            '{FUNC_TEST,        0,      0, 0, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_TEST,   -32768, -32768, 0, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_TEST,    32767,  32767, 0, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_TEST,    32767,      0, 0, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_TEST,   -32768,      0, 0, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_UNUSED,     -1,     -1, 1, '{1'b0, 7'd4, STAT_OK}},
            '{FUNC_CLEAR,       0,      0, 1, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_APPEND,      0,      0, 1, '{1'b0, 7'd1, STAT_OK}},
            '{FUNC_APPEND,      0,    100, 1, '{1'b0, 7'd2, STAT_OK}},
            '{FUNC_APPEND,    100,     50, 1, '{1'b0, 7'd3, STAT_OK}},
            '{FUNC_TEST,        0,     50, 0, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_TEST,       50,     50, 0, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_TEST,       -1,     50, 0, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_CLEAR,      -1,     -1, 1, '{1'b0, 7'd0, STAT_OK}},
            '{FUNC_TEST,       -1,     -1, 1, '{1'b0, 7'd0, STAT_INVALID}}
        };

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            issue_item(directed_rows[r].func, COORD_BITS'(directed_rows[r].x),
                       COORD_BITS'(directed_rows[r].y), directed_rows[r].typed,
                       directed_rows[r].answer);

        while (items_sent < 1400) begin
            if ($urandom_range(0, 99) < 82) begin
                // Random polygon: clear, build (some builds overrun the table), then probe it
                pick   = $urandom_range(0, 99);
                n_vert = (pick < 70) ? $urandom_range(3, 8) :
                         (pick < 92) ? $urandom_range(9, 30) : $urandom_range(60, 68);
                pick   = $urandom_range(0, 2);
                lim    = (pick == 0) ? 40 : (pick == 1) ? 2000 : 32768;
                min_x  = 32767; max_x = -32768; min_y = 32767; max_y = -32768;
                issue_item(FUNC_CLEAR, rand_coord(32768), rand_coord(32768), 0, no_answer);
                for (int k = 0; k < n_vert; k++) begin
                    vx = rand_coord(lim);
                    vy = rand_coord(lim);
                    if (vx < min_x) min_x = vx;
                    if (vx > max_x) max_x = vx;
                    if (vy < min_y) min_y = vy;
                    if (vy > max_y) max_y = vy;
                    issue_item(FUNC_APPEND, vx, vy, 0, no_answer);
                end
                n_tests = $urandom_range(3, 9);
                for (int k = 0; k < n_tests; k++) begin
                    pick = $urandom_range(0, 9);
                    vi   = $urandom_range(0, ((poly_len > 0) ? poly_len : 1) - 1);
                    qx   = COORD_BITS'(int'($urandom_range(0, max_x - min_x)) + min_x);
                    qy   = COORD_BITS'(int'($urandom_range(0, max_y - min_y)) + min_y);
                    if (pick == 7) begin
                        qx = poly_x[vi];
                    end else if (pick == 8) begin
                        qx = poly_x[vi];
                        qy = poly_y[vi];
                    end else if (pick == 9) begin
                        qx = rand_coord(32768);
                        qy = rand_coord(32768);
                    end
                    issue_item(FUNC_TEST, qx, qy, 0, no_answer);
                end
            end else begin
                // Noise: any code, any coordinates
                repeat ($urandom_range(1, 6))
                    issue_item(FUNC_W'($urandom()), rand_coord(32768), rand_coord(32768),
                               0, no_answer);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_answers.size() > 0) @(posedge i_clk);
        repeat (MAX_VERTICES + 10) @(posedge i_clk);

        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pip_pkg.sv
hw/rtl/pip_ram.sv
hw/rtl/point_in_polygon_test.sv
tb/sv/point_in_polygon_test_tb.sv
